@@ hdl/assert_macros.svh @@
// Assertion macros shared by the GPIO controller RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is held
`define GPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define GPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hdl/gpc_pkg.sv @@
// Types and constants for the GPIO pin controller.
// No dependencies; imported by gpio_pin_controller.
package gpc_pkg;

    localparam int NUM_PINS    = 54;
    localparam int COUNT_WIDTH = 16;

    localparam int PIN_W   = 6;
    localparam int PADS_W  = 54;
    localparam int EVENT_W = 16;

    typedef enum logic [2:0] {
        OP_CONFIG     = 3'd0,
        OP_WRITE      = 3'd1,
        OP_READ_PIN   = 3'd2,
        OP_SAMPLE     = 3'd3,
        OP_READ_COUNT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_ILLEGAL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2,
        EDGE_BAD  = 2'd3
    } edge_t;

    localparam logic [1:0] PULL_BAD    = 2'd3;
    localparam logic [2:0] FUNC_OUTPUT = 3'd1;

    // Request layout, first field in the highest bits
    typedef struct packed {
        logic [PADS_W-1:0] pad_levels;
        logic              drive_value;
        logic [1:0]        edge_mode;
        logic [1:0]        pull_mode;
        logic [2:0]        function_select;
        logic [PIN_W-1:0]  pin;
        logic [2:0]        opcode;
    } req_t;

    typedef struct packed {
        logic [PADS_W-1:0]  drive_enables;
        logic [PADS_W-1:0]  drive_levels;
        logic [EVENT_W-1:0] event_count;
        logic               pin_level;
        logic [1:0]         status;
    } res_t;

    localparam int REQ_W      = $bits(req_t);
    localparam int RES_W      = $bits(res_t);
    localparam int S_DATA_W   = ((REQ_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((RES_W + 7) / 8) * 8;

endpackage

@@ hdl/gpio_pin_controller.sv @@
// GPIO pin controller: request register, per-pin update lanes, result register.
// Depends on gpc_pkg and assert_macros.svh.
//
// Usage:
//   s_ channel carries requests: configure a pin, write an output latch bit,
//   read a pin, sample the pad levels, or read an edge counter.
//   m_ channel returns exactly one result per request: status, sampled level,
//   counter value before clearing, and the output latch and output enables
//   as they stand after the request.
//   m_tvalid rises once a request has moved from the request register into the
//   result register; one request per cycle is sustained while m_tready stays
//   high. Each request is held in a request register, then all 54 pin lanes
//   are updated in parallel as it moves into the result register.
//   Reset clears every pin to input, no edge detect, counters and previous
//   pad sample to zero, and empties both registers.
//   If the receiver stalls, the result stays in the result register and one
//   more request is still taken into the request register; s_tready then
//   drops until the result is taken.
`include "assert_macros.svh"

module gpio_pin_controller
    import gpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // opcode, pin, function_select, pull_mode, edge_mode, drive_value, pad_levels
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, pin_level, event_count, drive_levels, drive_enables
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   req_valid_reg, req_valid_next;
    req_t                   req_reg;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    logic [2:0]             func_reg  [NUM_PINS];
    logic [2:0]             func_next [NUM_PINS];
    edge_t                  edge_reg  [NUM_PINS];
    edge_t                  edge_next [NUM_PINS];
    logic [COUNT_WIDTH-1:0] cnt_reg   [NUM_PINS];
    logic [COUNT_WIDTH-1:0] cnt_next  [NUM_PINS];
    logic [NUM_PINS-1:0]    latch_reg, latch_next;
    logic [NUM_PINS-1:0]    prev_reg, prev_next;

    logic                   s_accept, advance, in_range;
    logic [NUM_PINS-1:0]    pads, sel, rise, fall;
    logic [COUNT_WIDTH-1:0] count_rd;
    logic                   level_rd;

    assign s_accept = s_tvalid && s_tready;
    assign advance  = req_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !req_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

    assign in_range = {1'b0, req_reg.pin} < (PIN_W + 1)'(NUM_PINS);
    assign pads     = req_reg.pad_levels[NUM_PINS-1:0];
    assign rise     = pads & ~prev_reg;
    assign fall     = ~pads & prev_reg;

    always_comb begin
        req_valid_next = req_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            req_valid_next = 1'b1;
        end else if (advance) begin
            req_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Per-pin lanes, then the result is assembled from the next state
    always_comb begin
        func_next  = func_reg;
        edge_next  = edge_reg;
        cnt_next   = cnt_reg;
        latch_next = latch_reg;
        prev_next  = prev_reg;
        out_next   = '0;
        count_rd   = '0;
        level_rd   = 1'b0;

        for (int i = 0; i < NUM_PINS; i++) begin
            sel[i] = in_range && (req_reg.pin == PIN_W'(i));
        end

        unique case (op_t'(req_reg.opcode)) inside
            OP_SAMPLE: begin
                for (int i = 0; i < NUM_PINS; i++) begin
                    if (((edge_reg[i] == EDGE_RISE && rise[i]) ||
                         (edge_reg[i] == EDGE_FALL && fall[i])) &&
                        cnt_reg[i] != COUNT_MAX) begin
                        cnt_next[i] = cnt_reg[i] + 1'b1;
                    end
                end
                prev_next = pads;
            end
            OP_CONFIG: begin
                for (int i = 0; i < NUM_PINS; i++) begin
                    if (sel[i]) begin
                        func_next[i] = req_reg.function_select;
                        edge_next[i] = (edge_t'(req_reg.edge_mode) == EDGE_BAD) ?
                                       EDGE_NONE : edge_t'(req_reg.edge_mode);
                    end
                end
                // pull setting is checked for the illegal code only; no pad pull control here
                if (!in_range) begin
                    out_next.status = ST_RANGE;
                end else if (req_reg.pull_mode == PULL_BAD ||
                             edge_t'(req_reg.edge_mode) == EDGE_BAD) begin
                    out_next.status = ST_ILLEGAL;
                end
            end
            OP_WRITE: begin
                for (int i = 0; i < NUM_PINS; i++) begin
                    if (sel[i]) begin
                        latch_next[i] = req_reg.drive_value;
                    end
                end
                if (!in_range) begin
                    out_next.status = ST_RANGE;
                end
            end
            OP_READ_PIN, OP_READ_COUNT: begin
                for (int i = 0; i < NUM_PINS; i++) begin
                    if (sel[i]) begin
                        count_rd    = count_rd | cnt_reg[i];
                        level_rd    = level_rd | prev_reg[i];
                        cnt_next[i] = '0;
                    end
                end
                if (!in_range) begin
                    out_next.status = ST_RANGE;
                end
                out_next.event_count = EVENT_W'(count_rd);
                if (op_t'(req_reg.opcode) == OP_READ_PIN) begin
                    out_next.pin_level = level_rd;
                end
            end
            default: begin
                // unused opcodes: no change, status ok
            end
        endcase

        for (int i = 0; i < NUM_PINS; i++) begin
            out_next.drive_levels[i]  = latch_next[i];
            out_next.drive_enables[i] = (func_next[i] == FUNC_OUTPUT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= '0;
            prev_reg      <= '0;
            for (int i = 0; i < NUM_PINS; i++) begin
                func_reg[i] <= '0;
                edge_reg[i] <= EDGE_NONE;
                cnt_reg[i]  <= '0;
            end
        end else begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                latch_reg <= latch_next;
                prev_reg  <= prev_next;
                func_reg  <= func_next;
                edge_reg  <= edge_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= req_t'(s_tdata[REQ_W-1:0]);
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    `GPC_ASSERT(a_no_overwrite, (s_accept && req_valid_reg) |-> advance,
                "request register overwritten before it moved on")
    `GPC_ASSERT(a_sample_kept,
                (advance && op_t'(req_reg.opcode) == OP_SAMPLE) |=> (prev_reg == $past(pads)),
                "pad sample not stored")
    `GPC_ASSERT(a_range_latch,
                (advance && !in_range && op_t'(req_reg.opcode) == OP_WRITE) |=>
                    (latch_reg == $past(latch_reg)),
                "out of range write changed the output latch")
    `GPC_ASSERT(a_err_no_count,
                (out_valid_reg && out_reg.status != ST_OK) |->
                    (out_reg.event_count == '0 && !out_reg.pin_level),
                "rejected request returned data")

endmodule

@@ verif/tb_gpio_pin_controller.sv @@
// Self-checking testbench for gpio_pin_controller: random and directed requests on the s_ stream,
// every result on the m_ stream compared with a built-in model of the pin state.
// Depends on gpc_pkg and the RTL of gpio_pin_controller.
`timescale 1ns / 1ps

module tb_gpio_pin_controller;
    import gpc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int HALF_PERIOD = CLK_PERIOD / 2;
    localparam int RESET_CYCLES = 11;
    localparam int N_RANDOM     = 1580;
    // back-to-back sample requests toggling every pad
    localparam int TOGGLE_SAMPLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;
    localparam logic [2:0] FUNC_INPUT = 3'd0;
    localparam logic [2:0] FUNC_ALT_TOP = 3'd7;
    localparam logic [1:0] PULL_NONE = 2'd0;
    localparam logic [1:0] PULL_LOW  = 2'd1;
    localparam logic [1:0] PULL_HIGH = 2'd2;

    typedef struct {
        req_t req;
        bit   tight;    // sent back to back, receiver never stalls
    } pending_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // model of the pin state
    logic [2:0]             pin_func  [NUM_PINS];
    logic [1:0]             pin_pull  [NUM_PINS];
    edge_t                  pin_edge  [NUM_PINS];
    logic [COUNT_WIDTH-1:0] edge_cnt  [NUM_PINS];
    logic [PADS_W-1:0]      drive_latch;
    logic [PADS_W-1:0]      last_pads;

    pending_t pend_q[$];
    res_t     result_q[$];
    pending_t nxt;

    int  tx_gap     = 0;
    bit  tight_mode = 1'b0;
    int  rx_stall   = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  hold_at    = 0;
    int  n_checked  = 0;
    int  n_errors   = 0;
    logic [PADS_W-1:0] gen_pads = '0;

    gpio_pin_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Applies one request to the pin model and returns the result it should give
    function automatic res_t gpio_predict(input req_t rq);
        res_t              rs;
        logic [PADS_W-1:0] rise;
        logic [PADS_W-1:0] fall;
        int                i;
        rs = '0;
        case (rq.opcode) inside
            OP_SAMPLE: begin
                rise = rq.pad_levels & ~last_pads;
                fall = ~rq.pad_levels & last_pads;
                for (i = 0; i < NUM_PINS; i++) begin
                    if (((pin_edge[i] == EDGE_RISE) && rise[i]) ||
                        ((pin_edge[i] == EDGE_FALL) && fall[i])) begin
                        if (edge_cnt[i] != '1)
                            edge_cnt[i] = edge_cnt[i] + 1'b1;
                    end
                end
                last_pads = rq.pad_levels;
            end
            OP_CONFIG, OP_WRITE, OP_READ_PIN, OP_READ_COUNT: begin
                if (rq.pin >= NUM_PINS) begin
                    rs.status = ST_RANGE;
                end else begin
                    case (rq.opcode)
                        OP_CONFIG: begin
                            pin_func[rq.pin] = rq.function_select;
                            // bad pull keeps the old one, rest still written
                            if (rq.pull_mode == PULL_BAD)
                                rs.status = ST_ILLEGAL;
                            else
                                pin_pull[rq.pin] = rq.pull_mode;
                            if (rq.edge_mode == EDGE_BAD) begin
                                pin_edge[rq.pin] = EDGE_NONE;
                                rs.status = ST_ILLEGAL;
                            end else begin
                                pin_edge[rq.pin] = edge_t'(rq.edge_mode);
                            end
                        end
                        OP_WRITE: drive_latch[rq.pin] = rq.drive_value;
                        default: begin
                            if (rq.opcode == OP_READ_PIN)
                                rs.pin_level = last_pads[rq.pin];
                            rs.event_count = edge_cnt[rq.pin][EVENT_W-1:0];
                            edge_cnt[rq.pin] = '0;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        rs.drive_levels = drive_latch;
        for (i = 0; i < NUM_PINS; i++)
            rs.drive_enables[i] = (pin_func[i] == FUNC_OUTPUT);
        return rs;
    endfunction

    function automatic req_t mk_req(input logic [2:0] op, input int pin, input logic [2:0] fsel,
                                    input logic [1:0] pull, input logic [1:0] edg,
                                    input logic drv, input logic [PADS_W-1:0] pads);
        req_t r;
        r.opcode          = op;
        r.pin             = pin[PIN_W-1:0];
        r.function_select = fsel;
        r.pull_mode       = pull;
        r.edge_mode       = edg;
        r.drive_value     = drv;
        r.pad_levels      = pads;
        return r;
    endfunction

    task automatic push_req(input req_t r, input bit tight);
        pending_t p;
        p.req   = r;
        p.tight = tight;
        pend_q.push_back(p);
    endtask

    // Idle length: mostly short, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic req_t random_req();
        req_t              r;
        logic [63:0]       raw;
        logic [PADS_W-1:0] flip;
        int                sel;
        int                k;
        raw = {$urandom(), $urandom()};
        r = '0;
        r.pad_levels      = raw[PADS_W-1:0];
        r.drive_value     = 1'($urandom_range(0, 1));
        r.function_select = 3'($urandom_range(0, 7));
        r.pull_mode       = ($urandom_range(0, 9) == 0) ? PULL_BAD : 2'($urandom_range(0, 2));
        r.edge_mode       = ($urandom_range(0, 9) == 0) ? EDGE_BAD : 2'($urandom_range(0, 2));
        sel = $urandom_range(0, 99);
        if (sel < 10)
            r.pin = PIN_W'($urandom_range(NUM_PINS, 63));
        else if (sel < 20)
            r.pin = ($urandom_range(0, 1) != 0) ? PIN_W'(NUM_PINS - 1) : PIN_W'(0);
        else
            r.pin = PIN_W'($urandom_range(0, NUM_PINS - 1));
        sel = $urandom_range(0, 99);
        if (sel < 18)      r.opcode = OP_CONFIG;
        else if (sel < 33) r.opcode = OP_WRITE;
        else if (sel < 48) r.opcode = OP_READ_PIN;
        else if (sel < 80) r.opcode = OP_SAMPLE;
        else if (sel < 95) r.opcode = OP_READ_COUNT;
        else if (sel < 97) r.opcode = OP_SPARE_A;
        else if (sel < 99) r.opcode = OP_SPARE_B;
        else               r.opcode = OP_SPARE_C;
        if (r.opcode == OP_SAMPLE) begin
            // in half the cases a few toggled pins against the last sample, so edges stay realistic
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                flip = '0;
                for (k = 0; k < $urandom_range(1, 6); k++)
                    flip[$urandom_range(0, PADS_W - 1)] = 1'b1;
                r.pad_levels = gen_pads ^ flip;
            end else if (sel == 8) begin
                r.pad_levels = '1;
            end else if (sel == 9) begin
                r.pad_levels = '0;
            end
            gen_pads = r.pad_levels;
        end
        return r;
    endfunction

    // Driver: takes requests from the pending queue, predicts at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            tx_gap     <= 0;
            tight_mode <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                result_q.push_back(gpio_predict(req_t'(s_tdata[REQ_W-1:0])));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (pend_q.size() > 0) begin
                    nxt = pend_q.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {{(S_DATA_W - REQ_W){1'b0}}, nxt.req};
                    tight_mode <= nxt.tight;
                    if (nxt.tight || $urandom_range(0, 9) < 6)
                        tx_gap <= 0;
                    else
                        tx_gap <= gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver: checks results, throttles m_tready
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_stall  <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[RES_W-1:0]);
                if (result_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected result: %h", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display({"result %0d mismatch: status %0d/%0d level %0d/%0d ",
                                      "count %0d/%0d levels %h/%h enables %h/%h (exp/act)"},
                                     n_checked, want.status, got.status,
                                     want.pin_level, got.pin_level,
                                     want.event_count, got.event_count,
                                     want.drive_levels, got.drive_levels,
                                     want.drive_enables, got.drive_enables);
                    end
                end
                n_checked++;
            end
            if (!hold_done && n_checked >= hold_at) begin
                // long back-pressure so the block fills and drops s_tready
                hold_done = 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (tight_mode) begin
                m_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                rx_stall <= gap_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int i;
        for (i = 0; i < NUM_PINS; i++) begin
            pin_func[i] = FUNC_INPUT;
            pin_pull[i] = PULL_NONE;
            pin_edge[i] = EDGE_NONE;
            edge_cnt[i] = '0;
        end
        drive_latch = '0;
        last_pads   = '0;

        // directed: reset state, range limits, illegal codes, spare opcodes
        push_req(mk_req(OP_READ_PIN, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_CONFIG, 0, FUNC_OUTPUT, PULL_LOW, EDGE_RISE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_CONFIG, NUM_PINS - 1, FUNC_ALT_TOP, PULL_HIGH, EDGE_FALL, 1'b1, '1),
                 1'b0);
        push_req(mk_req(OP_CONFIG, NUM_PINS, FUNC_OUTPUT, PULL_LOW, EDGE_RISE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_CONFIG, 63, FUNC_OUTPUT, PULL_BAD, EDGE_BAD, 1'b1, '1), 1'b0);
        push_req(mk_req(OP_CONFIG, 5, FUNC_OUTPUT, PULL_BAD, EDGE_RISE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_CONFIG, 6, FUNC_OUTPUT, PULL_HIGH, EDGE_BAD, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_WRITE, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b1, '0), 1'b0);
        push_req(mk_req(OP_WRITE, NUM_PINS - 1, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b1, '0),
                 1'b0);
        push_req(mk_req(OP_WRITE, 63, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b1, '0), 1'b0);
        push_req(mk_req(OP_SAMPLE, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '1), 1'b0);
        push_req(mk_req(OP_SAMPLE, 63, FUNC_ALT_TOP, PULL_BAD, EDGE_BAD, 1'b1, '0), 1'b0);
        push_req(mk_req(OP_READ_PIN, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_READ_COUNT, NUM_PINS - 1, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0,
                        '0), 1'b0);
        push_req(mk_req(OP_READ_COUNT, 60, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_READ_PIN, 60, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_SPARE_A, 1, FUNC_OUTPUT, PULL_LOW, EDGE_RISE, 1'b1, '1), 1'b0);
        push_req(mk_req(OP_SPARE_B, 2, FUNC_OUTPUT, PULL_LOW, EDGE_RISE, 1'b1, '1), 1'b0);
        push_req(mk_req(OP_SPARE_C, 63, FUNC_OUTPUT, PULL_BAD, EDGE_BAD, 1'b1, '1), 1'b0);
        push_req(mk_req(OP_WRITE, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b0);
        push_req(mk_req(OP_SAMPLE, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0,
                        54'h2AAAAAAAAAAAAA), 1'b0);
        push_req(mk_req(OP_READ_PIN, NUM_PINS - 1, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0),
                 1'b0);

        // edge counting: alternate the pads back to back on watched pins
        push_req(mk_req(OP_CONFIG, 1, FUNC_OUTPUT, PULL_NONE, EDGE_RISE, 1'b0, '0), 1'b1);
        push_req(mk_req(OP_CONFIG, 2, FUNC_INPUT, PULL_LOW, EDGE_FALL, 1'b0, '0), 1'b1);
        for (i = 0; i < TOGGLE_SAMPLES; i++)
            push_req(mk_req(OP_SAMPLE, 0, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0,
                            (i % 2 == 0) ? '1 : '0), 1'b1);
        push_req(mk_req(OP_READ_COUNT, 1, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b1);
        push_req(mk_req(OP_READ_PIN, 2, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b1);
        push_req(mk_req(OP_READ_COUNT, NUM_PINS - 1, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0,
                        '0), 1'b1);
        push_req(mk_req(OP_READ_COUNT, 1, FUNC_INPUT, PULL_NONE, EDGE_NONE, 1'b0, '0), 1'b1);
        gen_pads = '0;

        hold_at = pend_q.size() + 300;
        for (i = 0; i < N_RANDOM; i++)
            push_req(random_req(), 1'b0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0 && result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 1_250_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
